FILE: hw/rtl/dca_pkg.sv
// ----------------------------------------------------------------------------
// dca_pkg - shared definitions for the distinct count aggregate
// Value kinds, register indexes, sequencer states and key compare helpers.
// ----------------------------------------------------------------------------
package dca_pkg;

  // default depth of the seen-key table
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned KIND_W  = 2;

  // value kinds
  localparam logic [KIND_W-1:0] KIND_BITS       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOUBLE     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_COUNT_ONLY = 2'd3;

  // configuration register indexes
  localparam logic REG_DISTINCT_MODE = 1'b0;
  localparam logic REG_VALUE_KIND    = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // saturating count increment
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
  endfunction

  // key equality under the current kind; floats treat +0 == -0, NaN never matches
  function automatic logic keys_match(input logic [KEY_W-1:0]  a,
                                      input logic [KEY_W-1:0]  b,
                                      input logic [KIND_W-1:0] kind);
    logic a_nan_s, b_nan_s, a_nan_d, b_nan_d;
    logic res;
    a_nan_s = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan_s = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_nan_d = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
    b_nan_d = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    unique case (kind)
      KIND_SINGLE: begin
        if (a_nan_s || b_nan_s) res = 1'b0;
        else if ((a[30:0] == '0) && (b[30:0] == '0)) res = 1'b1;
        else res = (a[31:0] == b[31:0]);
      end
      KIND_DOUBLE: begin
        if (a_nan_d || b_nan_d) res = 1'b0;
        else if ((a[62:0] == '0) && (b[62:0] == '0)) res = 1'b1;
        else res = (a == b);
      end
      default: res = (a == b);
    endcase
    return res;
  endfunction

endpackage

FILE: hw/rtl/distinct_count_aggregate_core.sv
// ----------------------------------------------------------------------------
// distinct_count_aggregate_core - streaming COUNT / COUNT DISTINCT aggregate
// Counts non-null values per group, optionally only distinct ones, using a
// key table scanned by a single shared comparator.
// ----------------------------------------------------------------------------
// One result beat is produced for every input beat, carrying the count after
// that beat is applied. Null beats, ALL mode and the count-only kind skip
// the scan and go straight to the done state. In DISTINCT mode the key table
// (one read port, registered read data) is scanned one stored key per cycle
// through one comparator, up to the keys_used stored keys (at most
// TABLE_DEPTH); the scan stops early on a match.
// in_tready is high only while the sequencer is idle. A finished result sits
// in the output register, so the next beat may be accepted while it waits.
// start_group clears the group state in the same cycle as the beat is taken;
// the table needs no clearing pass.
module distinct_count_aggregate_core #(
  parameter int unsigned TABLE_DEPTH = dca_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value_key
  input  logic [1:0]  in_tuser,   // [0] value_is_null, [1] start_group
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] running_count
  output logic [1:0]  out_tuser,  // [0] count_is_null, [1] table_overflow
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_wdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam int unsigned KW = dca_pkg::KEY_W;
  localparam int unsigned NW = dca_pkg::COUNT_W;

  // registers
  dca_pkg::state_t state_r, state_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            pend_r, pend_nxt;
  logic [CW-1:0]   used_r, used_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic            nonnull_r, nonnull_nxt;
  logic            ovf_r, ovf_nxt;
  logic            mode_r;
  logic [1:0]      kind_r;
  logic            out_valid_r, out_valid_nxt;
  logic [NW-1:0]   out_count_r;
  logic            out_null_r, out_ovf_r;
  logic            out_load;

  // key table
  logic [KW-1:0]   mem [TABLE_DEPTH];
  logic [KW-1:0]   rd_data_r;
  logic            rd_en, mem_we;
  logic            match;

  logic            in_null, in_start;
  logic [NW-1:0]   count_base;

  assign in_null    = in_tuser[0];
  assign in_start   = in_tuser[1];
  assign count_base = in_start ? '0 : count_r;
  assign match      = dca_pkg::keys_match(rd_data_r, key_r, kind_r);

  assign in_tready  = (state_r == dca_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = {out_ovf_r, out_null_r};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    used_nxt    = used_r;
    count_nxt   = count_r;
    nonnull_nxt = nonnull_r;
    ovf_nxt     = ovf_r;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      dca_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_start) begin
            used_nxt    = '0;
            count_nxt   = '0;
            nonnull_nxt = 1'b0;
            ovf_nxt     = 1'b0;
          end
          key_nxt  = (kind_r == dca_pkg::KIND_SINGLE) ? {32'b0, in_tdata[31:0]} : in_tdata;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          state_nxt = dca_pkg::ST_DONE;
          if (!in_null) begin
            nonnull_nxt = 1'b1;
            if (!mode_r || (kind_r == dca_pkg::KIND_COUNT_ONLY)) begin
              count_nxt = dca_pkg::sat_inc(count_base);
            end else begin
              state_nxt = dca_pkg::ST_SCAN;
            end
          end
        end
      end
      dca_pkg::ST_SCAN: begin
        priority if (pend_r && match) begin
          // key already stored: not counted
          pend_nxt  = 1'b0;
          state_nxt = dca_pkg::ST_DONE;
        end else if (idx_r < used_r) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          // absent: store if room, count either way
          if (used_r < DEPTH_C) begin
            mem_we   = 1'b1;
            used_nxt = used_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          count_nxt = dca_pkg::sat_inc(count_r);
          state_nxt = dca_pkg::ST_DONE;
        end else begin
          // last compare missed, drain
          pend_nxt = 1'b0;
        end
      end
      dca_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = dca_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dca_pkg::ST_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dca_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      idx_r       <= '0;
      used_r      <= '0;
      count_r     <= '0;
      nonnull_r   <= 1'b0;
      ovf_r       <= 1'b0;
      mode_r      <= 1'b0;
      kind_r      <= dca_pkg::KIND_BITS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      nonnull_r   <= nonnull_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dca_pkg::REG_DISTINCT_MODE: mode_r <= cfg_wdata[0];
          dca_pkg::REG_VALUE_KIND:    kind_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (out_load) begin
      out_count_r <= count_r;
      out_null_r  <= !nonnull_r;
      out_ovf_r   <= ovf_r;
    end
  end

  // key table: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[used_r[AW-1:0]] <= key_r;
    if (rd_en) rd_data_r <= mem[idx_r[AW-1:0]];
  end

`ifndef NO_ASSERTIONS
  // fill count never passes the table depth
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_C)
    else $error("key table fill count beyond depth");

  // overflow only ever set with a full table
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (used_r == DEPTH_C))
    else $error("overflow flagged with free table entries");

  // a non-zero count implies a non-null value was seen
  a_count_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> nonnull_r)
    else $error("count without non-null value");

  // a finished result is not overwritten while it waits
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_count_r))
    else $error("waiting result overwritten");
`endif

endmodule
